/* hw/rtl/i2cms_pkg.sv */
package i2cms_pkg;

	localparam int unsigned QueueDepthDefault = 2;
	localparam logic [7:0] AckTimeoutReset = 8'd10;
	localparam logic [7:0] PollNever = 8'd255;

	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_WRITE = 3'd2;
	localparam logic [2:0] OP_READ  = 3'd3;
	localparam logic [2:0] OP_WAIT  = 3'd4;
	localparam logic [2:0] OP_PROBE = 3'd5;

	typedef enum logic [2:0] {
		K_START = 3'd0,
		K_STOP  = 3'd1,
		K_WRITE = 3'd2,
		K_READ  = 3'd3,
		K_WAIT  = 3'd4,
		K_PROBE = 3'd5,
		K_HOLD  = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       ack_bit;
		logic [7:0] samples;
		logic       fail;
	} cmd_t;

	typedef struct packed {
		logic scl;
		logic sda;
	} lv_t;

	typedef struct packed {
		lv_t  lv;
		logic fin;
	} ph_t;

	function automatic lv_t start_lv(logic [1:0] s);
		lv_t r;
		unique case (s)
			2'd0: r = '{scl: 1'b1, sda: 1'b1};
			2'd1: r = '{scl: 1'b1, sda: 1'b0};
			default: r = '{scl: 1'b0, sda: 1'b0};
		endcase
		return r;
	endfunction

	function automatic lv_t stop_lv(logic [1:0] s);
		lv_t r;
		unique case (s)
			2'd0: r = '{scl: 1'b0, sda: 1'b0};
			2'd1: r = '{scl: 1'b1, sda: 1'b0};
			default: r = '{scl: 1'b1, sda: 1'b1};
		endcase
		return r;
	endfunction

	function automatic lv_t write_lv(logic [7:0] b, logic [4:0] w);
		lv_t r;
		if (w[4]) begin
			r = '{scl: 1'b0, sda: b[0]};
		end else begin
			r = '{scl: w[0], sda: b[3'd7 - w[3:1]]};
		end
		return r;
	endfunction

	function automatic lv_t wait_lv(logic fail, logic [2:0] w);
		lv_t r;
		if (w == 3'd1) begin
			r = '{scl: 1'b1, sda: 1'b1};
		end else if (fail && w >= 3'd2) begin
			r = stop_lv(2'(w - 3'd2));
		end else begin
			r = '{scl: 1'b0, sda: 1'b1};
		end
		return r;
	endfunction

	function automatic ph_t phase_at(cmd_t c, logic [4:0] step, lv_t cur);
		ph_t        r;
		logic [4:0] w;
		logic [4:0] wl;
		w  = 5'd0;
		wl = c.fail ? 5'd5 : 5'd3;
		r  = '{lv: cur, fin: 1'b1};
		unique case (c.kind)
			K_START: begin
				r.lv  = start_lv(step[1:0]);
				r.fin = (step == 5'd2);
			end
			K_STOP: begin
				r.lv  = stop_lv(step[1:0]);
				r.fin = (step == 5'd2);
			end
			K_WRITE: begin
				r.lv  = write_lv(c.data_byte, step);
				r.fin = (step == 5'd16);
			end
			K_READ: begin
				if (step < 5'd16) begin
					r.lv = '{scl: step[0], sda: 1'b1};
				end else if (step < 5'd19) begin
					r.lv = '{scl: (step == 5'd17), sda: c.ack_bit};
				end else begin
					r.lv = '{scl: 1'b0, sda: 1'b1};
				end
				r.fin = c.ack_bit ? (step == 5'd18) : (step == 5'd19);
			end
			K_WAIT: begin
				r.lv  = wait_lv(c.fail, step[2:0]);
				r.fin = (step == (c.fail ? 5'd4 : 5'd2));
			end
			K_PROBE: begin
				if (step < 5'd3) begin
					r.lv = start_lv(step[1:0]);
				end else if (step < 5'd20) begin
					r.lv = write_lv(c.data_byte, 5'(step - 5'd3));
				end else begin
					w = 5'(step - 5'd20);
					if (w < wl) begin
						r.lv = wait_lv(c.fail, w[2:0]);
					end else begin
						r.lv = stop_lv(2'(w - wl));
					end
				end
				r.fin = (step == (c.fail ? 5'd27 : 5'd25));
			end
			default: begin
				r.lv  = cur;
				r.fin = 1'b1;
			end
		endcase
		return r;
	endfunction

endpackage

/* hw/rtl/i2cms_front.sv */
module i2cms_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        operation,
	input  logic [7:0]        data_byte,
	input  logic              send_ack,
	input  logic [7:0]        sda_samples,
	input  logic [7:0]        ack_high_polls,
	output logic              push,
	output i2cms_pkg::cmd_t   push_cmd,
	input  logic              q_ready
);
	import i2cms_pkg::*;

	logic [7:0] ack_timeout_q;
	kind_t      kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= AckTimeoutReset;
		end else if (cfg_we) begin
			ack_timeout_q <= cfg_wdata;
		end
	end

	always_comb begin
		unique case (operation)
			OP_START: kind = K_START;
			OP_STOP:  kind = K_STOP;
			OP_WRITE: kind = K_WRITE;
			OP_READ:  kind = K_READ;
			OP_WAIT:  kind = K_WAIT;
			OP_PROBE: kind = K_PROBE;
			default:  kind = K_HOLD;
		endcase
	end

	assign in_ready = q_ready;
	assign push     = in_valid && q_ready;

	always_comb begin
		push_cmd.kind      = kind;
		push_cmd.data_byte = data_byte;
		push_cmd.ack_bit   = ~send_ack;
		push_cmd.samples   = sda_samples;
		push_cmd.fail      = (ack_high_polls == PollNever) || (ack_high_polls > ack_timeout_q);
	end

endmodule

/* hw/rtl/i2cms_queue.sv */
module i2cms_queue #(
	parameter int unsigned DEPTH = i2cms_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cms_pkg::cmd_t push_cmd,
	output logic            q_ready,
	output logic            q_valid,
	output i2cms_pkg::cmd_t q_cmd,
	input  logic            pop
);
	import i2cms_pkg::*;

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	cmd_t          entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_ready = (count_q != CW'(DEPTH));
	assign q_valid = (count_q != '0);
	assign q_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				count_q <= CW'(count_q + 1'b1);
			end else if (pop && !push) begin
				count_q <= CW'(count_q - 1'b1);
			end
		end
	end

endmodule

/* hw/rtl/i2cms_back.sv */
module i2cms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  i2cms_pkg::cmd_t q_cmd,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            scl_level,
	output logic            sda_level,
	output logic [7:0]      read_data,
	output logic            ack_error,
	output logic            last
);
	import i2cms_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t state_q;
	cmd_t       cmd_q;
	logic [4:0] step_q;
	lv_t        bus_q;
	logic       out_valid_q;
	lv_t        out_lv_q;
	logic [7:0] out_rd_q;
	logic       out_err_q;
	logic       out_last_q;
	ph_t        ph;
	logic       adv;

	assign ph  = phase_at(cmd_q, step_q, bus_q);
	assign adv = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= q_cmd;
		end
		if (adv) begin
			out_lv_q   <= ph.lv;
			out_last_q <= ph.fin;
			out_rd_q   <= (ph.fin && cmd_q.kind == K_READ) ? cmd_q.samples : 8'd0;
			out_err_q  <= ph.fin && cmd_q.fail && (cmd_q.kind == K_WAIT || cmd_q.kind == K_PROBE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			bus_q       <= '{scl: 1'b1, sda: 1'b1};
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (q_valid) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						bus_q  <= ph.lv;
						step_q <= 5'(step_q + 1'b1);
						if (ph.fin) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = out_lv_q.scl;
	assign sda_level = out_lv_q.sda;
	assign read_data = out_rd_q;
	assign ack_error = out_err_q;
	assign last      = out_last_q;

endmodule

/* hw/rtl/i2c_master_byte_sequencer.sv */
// a command is held in the queue entry and then the sequencer's command register, and
// each phase beat is registered at the output; throughput: one phase beat per cycle while
//   out_ready allows, plus a load step per command; probe with failed ack wait is longest
// commands wait in a small queue; input beats are taken during a run while it has room
// reset: arst_n asynchronous, bus_q returns to released, ack_timeout to 10, queue empties
module i2c_master_byte_sequencer #(
	parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QueueDepthDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       send_ack,
	input  logic [7:0] sda_samples,
	input  logic [7:0] ack_high_polls,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_level,
	output logic       sda_level,
	output logic [7:0] read_data,
	output logic       ack_error,
	output logic       last
);
	import i2cms_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic q_ready;
	logic q_valid;
	cmd_t q_cmd;
	logic pop;

	i2cms_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.data_byte      (data_byte),
		.send_ack       (send_ack),
		.sda_samples    (sda_samples),
		.ack_high_polls (ack_high_polls),
		.push           (push),
		.push_cmd       (push_cmd),
		.q_ready        (q_ready)
	);

	i2cms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.q_ready  (q_ready),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop)
	);

	i2cms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.scl_level (scl_level),
		.sda_level (sda_level),
		.read_data (read_data),
		.ack_error (ack_error),
		.last      (last)
	);

endmodule
